>>> rtl/isotp_receive_reassembler_unit_assert.svh
// ----------------------------------------------------------------------------
// isotp receive reassembler assertion macros
// shared property forms for the concurrent checks of the reassembler
// ----------------------------------------------------------------------------
`ifndef ISOTP_RECEIVE_REASSEMBLER_UNIT_ASSERT_SVH
`define ISOTP_RECEIVE_REASSEMBLER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ISOTP_RR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ISOTP_RR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/isotp_rr_pkg.sv
// ----------------------------------------------------------------------------
// isotp_rr_pkg
// types and constants shared by the receive reassembler modules
// ----------------------------------------------------------------------------
package isotp_rr_pkg;

  // frame kinds from the upper nibble of byte 0
  localparam logic [3:0] KIND_SINGLE = 4'h0;
  localparam logic [3:0] KIND_FIRST  = 4'h1;
  localparam logic [3:0] KIND_CONSEC = 4'h2;

  // byte counts per frame kind
  localparam logic [2:0] MAX_CHUNK   = 3'd7;
  localparam logic [2:0] FIRST_BYTES = 3'd6;

  // item field widths
  localparam int unsigned IdW    = 29;
  localparam int unsigned DataW  = 64;
  localparam int unsigned IdxW   = 12;
  localparam int unsigned LenW   = 12;
  localparam int unsigned CntW   = 13;
  localparam int unsigned AddrW  = 14;
  localparam int unsigned InTdW  = 112;
  localparam int unsigned OutTdW = 24;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_SINGLE = 2'd1,
    ST_TOO_LONG   = 2'd2,
    ST_SEQ_ERR    = 2'd3
  } isotp_rr_status_e;

  // byte write burst handed from control to the store
  typedef struct packed {
    logic [2:0]       count;
    logic [AddrW-1:0] base;
    logic [55:0]      bytes;
  } isotp_rr_wr_t;

  // per-item result of a frame
  typedef struct packed {
    isotp_rr_status_e status;
    logic             done;
    logic [LenW-1:0]  length;
  } isotp_rr_res_t;

endpackage

>>> rtl/isotp_rr_store.sv
// ----------------------------------------------------------------------------
// isotp_rr_store
// payload memory with a byte write sequencer and a registered read port
// ----------------------------------------------------------------------------
module isotp_rr_store import isotp_rr_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_start_i,
  input  isotp_rr_wr_t                      wr_i,
  input  logic                              rd_en_i,
  input  logic [$clog2(BUFFER_BYTES)-1:0]   rd_addr_i,
  output logic [7:0]                        rd_data_o,
  output logic                              busy_o
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam logic [AddrW-1:0] BufLimit = AddrW'(BUFFER_BYTES);

  logic [7:0]       mem [BUFFER_BYTES];
  logic [2:0]       left_q, left_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [55:0]      bytes_q, bytes_d;
  logic             wr_en;

  // burst sequencer: one byte per cycle
  always_comb begin
    left_d  = left_q;
    addr_d  = addr_q;
    bytes_d = bytes_q;
    if (wr_start_i) begin
      left_d  = wr_i.count;
      addr_d  = wr_i.base;
      bytes_d = wr_i.bytes;
    end else if (left_q != 3'd0) begin
      left_d  = left_q - 3'd1;
      addr_d  = addr_q + AddrW'(1);
      bytes_d = {8'h00, bytes_q[55:8]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 3'd0;
    end else begin
      left_q <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    bytes_q <= bytes_d;
  end

  // writes past the end of the store are dropped
  assign wr_en  = (left_q != 3'd0) && (addr_q < BufLimit);
  assign busy_o = (left_q != 3'd0);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[addr_q[AW-1:0]] <= bytes_q[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

>>> rtl/isotp_rr_ctrl.sv
// ----------------------------------------------------------------------------
// isotp_rr_ctrl
// frame decode, reception state and write burst generation
// ----------------------------------------------------------------------------
module isotp_rr_ctrl import isotp_rr_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IdW-1:0]   cfg_wdata_i,
  input  logic             frame_acc_i,
  input  logic [IdW-1:0]   frame_id_i,
  input  logic [DataW-1:0] frame_data_i,
  output isotp_rr_wr_t     wr_o,
  output isotp_rr_res_t    res_o
);

  localparam logic [CntW-1:0] LenLimit = CntW'(BUFFER_BYTES);

  logic [IdW-1:0]  rid_q;
  logic [LenW-1:0] exp_q, exp_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [3:0]      seq_q, seq_d;
  logic            rcv_q, rcv_d;

  logic [3:0]      kind;
  logic [3:0]      nib;
  logic [LenW-1:0] first_len;
  logic [15:0]     remain;
  logic [2:0]      chunk;
  logic [CntW-1:0] cnt_sum;

  assign kind      = frame_data_i[7:4];
  assign nib       = frame_data_i[3:0];
  assign first_len = {nib, frame_data_i[15:8]};
  assign remain    = 16'(exp_q) - 16'(cnt_q);
  assign chunk     = (remain > 16'(MAX_CHUNK)) ? MAX_CHUNK : remain[2:0];
  assign cnt_sum   = cnt_q + CntW'(chunk);

  // decode one frame against the current reception state
  always_comb begin
    exp_d = exp_q;
    cnt_d = cnt_q;
    seq_d = seq_q;
    rcv_d = rcv_q;
    wr_o  = '0;
    res_o = '0;
    if (frame_id_i == rid_q) begin
      case (kind)
        KIND_SINGLE: begin
          if (nib == 4'd0 || nib > 4'(MAX_CHUNK)) begin
            res_o.status = ST_BAD_SINGLE;
          end else begin
            wr_o.count   = nib[2:0];
            wr_o.bytes   = frame_data_i[63:8];
            res_o.done   = 1'b1;
            res_o.length = LenW'(nib);
          end
        end
        KIND_FIRST: begin
          exp_d = first_len;
          if ({1'b0, first_len} > LenLimit) begin
            res_o.status = ST_TOO_LONG;
          end else begin
            wr_o.count = FIRST_BYTES;
            wr_o.bytes = {8'h00, frame_data_i[63:16]};
            cnt_d      = CntW'(FIRST_BYTES);
            seq_d      = 4'd1;
            rcv_d      = 1'b1;
          end
        end
        KIND_CONSEC: begin
          if (rcv_q) begin
            if (nib != seq_q) begin
              rcv_d        = 1'b0;
              res_o.status = ST_SEQ_ERR;
            end else begin
              seq_d      = seq_q + 4'd1;
              wr_o.count = chunk;
              wr_o.base  = AddrW'(cnt_q);
              wr_o.bytes = frame_data_i[63:8];
              cnt_d      = cnt_sum;
              if (cnt_sum >= {1'b0, exp_q}) begin
                rcv_d        = 1'b0;
                res_o.done   = 1'b1;
                res_o.length = exp_q;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // reception state moves only on an accepted frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rid_q <= '0;
      exp_q <= '0;
      cnt_q <= '0;
      seq_q <= '0;
      rcv_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rid_q <= cfg_wdata_i;
      end
      if (frame_acc_i) begin
        exp_q <= exp_d;
        cnt_q <= cnt_d;
        seq_q <= seq_d;
        rcv_q <= rcv_d;
      end
    end
  end

endmodule

>>> rtl/isotp_receive_reassembler_unit.sv
// ----------------------------------------------------------------------------
// isotp_receive_reassembler_unit
// iso-tp receive reassembly of can frames into a byte payload memory
// ----------------------------------------------------------------------------
// channel  | direction | tdata (low bit first)                  | tuser
// s_axis   | in        | frame_id, frame_data, read_index, pad  | cmd
// m_axis   | out       | status, message_done, message_length,  | -
//          |           | read_data, pad                         |
// cfg      | in        | cfg_we_i / cfg_wdata_i = receive_id    | -
//
// a read item does not hold the input; a frame item holds the input while the
// payload bytes it writes (0 to 7) go in one at a time, as the memory has one
// write port. reads wait until pending byte writes have gone into the memory.
// results pass a decode stage and an output register.
// reset clears control state only; the payload memory is not cleared.
// ----------------------------------------------------------------------------
`include "isotp_receive_reassembler_unit_assert.svh"

module isotp_receive_reassembler_unit import isotp_rr_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IdW-1:0]    cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // frame_id[28:0], frame_data[92:29], read_index[104:93], zero[111:105]
  input  logic [InTdW-1:0]  s_axis_tdata,
  // cmd[0]
  input  logic              s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // status[1:0], message_done[2], message_length[14:3], read_data[22:15], zero[23]
  output logic [OutTdW-1:0] m_axis_tdata
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam logic [AddrW-1:0] BufLimit = AddrW'(BUFFER_BYTES);

  logic [IdW-1:0]   in_id;
  logic [DataW-1:0] in_data;
  logic [IdxW-1:0]  in_idx;
  logic             in_acc;
  logic             frame_acc;
  logic             read_acc;
  logic             busy;
  logic [7:0]       rd_data;
  isotp_rr_wr_t     wr;
  isotp_rr_res_t    res;

  logic             st_valid_q;
  isotp_rr_res_t    st_res_q;
  logic             st_rd_q;
  logic             st_move;
  logic             out_valid_q;
  logic [22:0]      out_data_q;

  assign in_id   = s_axis_tdata[28:0];
  assign in_data = s_axis_tdata[92:29];
  assign in_idx  = s_axis_tdata[104:93];

  // accept while no byte writes are pending and the decode stage can drain
  assign st_move       = st_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !busy && (!st_valid_q || st_move);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign frame_acc     = in_acc && !s_axis_tuser;
  assign read_acc      = in_acc && s_axis_tuser;

  isotp_rr_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .frame_acc_i (frame_acc),
    .frame_id_i  (in_id),
    .frame_data_i(in_data),
    .wr_o        (wr),
    .res_o       (res)
  );

  isotp_rr_store #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_start_i(frame_acc),
    .wr_i      (wr),
    .rd_en_i   (read_acc),
    .rd_addr_i (in_idx[AW-1:0]),
    .rd_data_o (rd_data),
    .busy_o    (busy)
  );

  // decode stage: frame result or pending memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (in_acc) begin
      st_valid_q <= 1'b1;
    end else if (st_move) begin
      st_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      st_res_q <= s_axis_tuser ? '0 : res;
      st_rd_q  <= s_axis_tuser && ({2'b00, in_idx} < BufLimit);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st_move) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_move) begin
      out_data_q <= {(st_rd_q ? rd_data : 8'h00), st_res_q.length, st_res_q.done,
                     st_res_q.status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_data_q};

  // checks
  `ISOTP_RR_ASSERT_NOW(a_read_after_writes, read_acc, !busy,
    "read accepted while byte writes are pending")
  `ISOTP_RR_ASSERT_NEXT(a_burst_starts, frame_acc && (wr.count != 3'd0), busy,
    "write burst did not start after a frame")
  `ISOTP_RR_ASSERT_NOW(a_done_is_ok, m_axis_tvalid && m_axis_tdata[2],
    m_axis_tdata[1:0] == ST_OK, "completed message carries an error status")

endmodule
